>>> rtl/core/rrq_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue package
// Shared command and status codes, result flags and default sizes.
// ----------------------------------------------------------------------------
package rrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  typedef enum logic [1:0] {
    MODE_INIT      = 2'd0,
    MODE_READY     = 2'd1,
    MODE_NOT_READY = 2'd2,
    MODE_SCHEDULE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic    switched;
    status_t status;
  } res_flags_t;

endpackage

>>> rtl/core/rrq_mem.sv
// ----------------------------------------------------------------------------
// Ready queue storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rrq_mem import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ID_BITS-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ID_BITS-1:0] rd_data
);

  logic [ID_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [ID_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/rrq_ctrl.sv
// ----------------------------------------------------------------------------
// Ready queue sequencer
// Circular queue pointers, running thread and the read-modify-write passes.
// ----------------------------------------------------------------------------
module rrq_ctrl import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mode_t              cmd_mode,
  input  logic [ID_BITS-1:0] cmd_id,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [ID_BITS-1:0] rd_data,
  output logic               wr_en,
  output logic [IDX_W-1:0]   wr_addr,
  output logic [ID_BITS-1:0] wr_data,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [ID_BITS-1:0] res_running,
  output logic [CNT_W-1:0]   res_queued,
  output res_flags_t         res_flags
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SCHED,
    S_RESP
  } state_t;

  state_t             state_r,   state_nxt;
  logic [IDX_W-1:0]   head_r,    head_nxt;
  logic [CNT_W-1:0]   count_r,   count_nxt;
  logic [ID_BITS-1:0] running_r, running_nxt;
  logic [ID_BITS-1:0] id_r,      id_nxt;
  res_flags_t         flags_r,   flags_nxt;
  logic [CNT_W-1:0]   rd_idx_r,  rd_idx_nxt;
  logic [CNT_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_valid_r, cmp_valid_nxt;
  logic               found_r,   found_nxt;
  logic               hit;

  // Physical slot of the entry at offset off from the head
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign hit = cmp_valid_r && !found_r && (rd_data == id_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    running_nxt   = running_r;
    id_nxt        = id_r;
    flags_nxt     = flags_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = 1'b0;
    found_nxt     = found_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          id_nxt    = cmd_id;
          flags_nxt = '{switched: 1'b0, status: ST_OK};
          state_nxt = S_RESP;
          unique case (cmd_mode)
            MODE_INIT: begin
              running_nxt = cmd_id;
              count_nxt   = '0;
              head_nxt    = '0;
            end
            MODE_READY: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                flags_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot(head_r, count_r);
                wr_data   = cmd_id;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_NOT_READY: begin
              if (count_r == '0) begin
                flags_nxt.status = ST_MISSING;
              end else begin
                rd_idx_nxt = '0;
                found_nxt  = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            MODE_SCHEDULE: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = S_SCHED;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; compare the entry read last cycle
        if (rd_idx_r != count_r) begin
          rd_en         = 1'b1;
          rd_addr       = slot(head_r, rd_idx_r);
          rd_idx_nxt    = rd_idx_r + 1'b1;
          cmp_idx_nxt   = rd_idx_r;
          cmp_valid_nxt = 1'b1;
        end
        if (cmp_valid_r) begin
          if (hit) begin
            found_nxt = 1'b1;
          end else if (found_r) begin
            // Close the gap: move this entry one place toward the head
            wr_en   = 1'b1;
            wr_addr = slot(head_r, cmp_idx_r - 1'b1);
            wr_data = rd_data;
          end
          if (cmp_idx_r == count_r - 1'b1) begin
            state_nxt = S_RESP;
            if (found_r || hit) begin
              count_nxt = count_r - 1'b1;
            end else begin
              flags_nxt.status = ST_MISSING;
            end
          end
        end
      end

      S_SCHED: begin
        // Head leaves first, so on a full queue the tail slot is the old head
        wr_en              = 1'b1;
        wr_addr            = slot(head_r, count_r);
        wr_data            = running_r;
        running_nxt        = rd_data;
        head_nxt           = slot(head_r, CNT_W'(1));
        flags_nxt.switched = 1'b1;
        state_nxt          = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      running_r   <= '0;
      cmp_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      running_r   <= running_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    flags_r   <= flags_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
  end

  assign cmd_ready   = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_RESP);
  assign res_running = running_r;
  assign res_queued  = count_r;
  assign res_flags   = flags_r;

endmodule

>>> rtl/core/round_robin_ready_queue.sv
// ----------------------------------------------------------------------------
// Round-robin ready queue
// Thread ready queue with a running-thread register and one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the command (init, ready, not ready,
//   schedule), in_tdata the thread identifier. Every command yields exactly one
//   result transaction on the output stream carrying the running thread, the
//   switched flag, the queue occupancy and a status code.
//   The queue is a circular buffer in a one-read, one-write memory; the head
//   pointer, count and running thread sit in flip-flops.
//   Steps per command: init, ready, and not ready or schedule on an empty
//   queue go straight to the result; schedule on a non-empty queue does one
//   memory read of the head, then the write-back of the old thread.
//   Not ready on a non-empty queue scans every queued entry through the memory
//   read port, one per cycle, moving later entries up as it goes.
//   Reset (rst_n low, synchronous) empties the queue and makes thread 0 the
//   running thread; memory contents are not cleared.
//   A result waits in the output register while out_tready is low; the next
//   command is still taken and worked on, and holds only when its own result
//   finds the output register occupied.
// ----------------------------------------------------------------------------
module round_robin_ready_queue import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_W       = ((ID_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ID_BITS + 1 + CNT_W + 2,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,  // thread_id
  input  logic [1:0]       in_tuser,  // mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata  // running_id, switched, queued, status
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;

  logic               res_valid;
  logic               res_ready;
  logic [ID_BITS-1:0] res_running;
  logic [CNT_W-1:0]   res_queued;
  res_flags_t         res_flags;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  rrq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd_mode    (mode_t'(in_tuser)),
    .cmd_id      (in_tdata[ID_BITS-1:0]),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_running (res_running),
    .res_queued  (res_queued),
    .res_flags   (res_flags)
  );

  // Take a new result when the output register is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Pack fields from the lowest bit up, zero padded to whole bytes
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= OUT_W'({res_flags.status, res_queued, res_flags.switched, res_running});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
